// ===== rtl/tclg_pkg.sv =====
// shared types and constants of the two-colour life generation core
`timescale 1ns / 1ps

package tclg_pkg;

    // cell codes
    localparam logic [1:0] CODE_DEAD = 2'd0;
    localparam logic [1:0] CODE_P0   = 2'd1;
    localparam logic [1:0] CODE_P1   = 2'd2;
    localparam logic [1:0] CODE_BAD  = 2'd3;

    localparam int CODE_W  = 2;
    localparam int CFG_W   = 6;
    localparam int TALLY_W = 11;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    // configuration register indexes
    localparam logic CFG_BOARD_WIDTH  = 1'b0;
    localparam logic CFG_BOARD_HEIGHT = 1'b1;

    localparam int BOARD_WIDTH_RST  = 18;
    localparam int BOARD_HEIGHT_RST = 16;
    localparam int DIM_MIN          = 3;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_TAIL,
        ST_FLUSH,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_STEP,
        PUSH_ZERO,
        PUSH_FLUSH
    } push_src_t;

    typedef struct packed {
        push_src_t push_src;
        logic      clear_win;
        logic      mem_we;
        logic      zero_top;
        logic      emit;
        logic      last;
        logic      clear_tally;
    } dp_cmd_t;

    typedef struct packed {
        logic [TALLY_W-1:0] count_player1;
        logic [TALLY_W-1:0] count_player0;
        logic               frame_last;
        logic [CODE_W-1:0]  next_code;
    } result_t;

endpackage

// ===== rtl/tclg_ctrl.sv =====
// controller: board size registers, raster position and the row/flush sequencer
`timescale 1ns / 1ps

module tclg_ctrl import tclg_pkg::*; #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32,
    localparam int COL_W     = $clog2(MAX_WIDTH),
    localparam int H_CAP     = (MAX_HEIGHT < (1 << CFG_W) - 1) ? MAX_HEIGHT : (1 << CFG_W) - 1,
    localparam int ROW_W     = $clog2(H_CAP)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             buf_full,
    output dp_cmd_t          cmd,
    output logic [COL_W-1:0] wr_addr,
    output logic [COL_W-1:0] rd_addr
);

    localparam int RST_W = (BOARD_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : BOARD_WIDTH_RST;
    localparam int RST_H = (BOARD_HEIGHT_RST > H_CAP) ? H_CAP : BOARD_HEIGHT_RST;

    state_t           state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] last_col_reg, last_col_next;
    logic [ROW_W-1:0] last_row_reg, last_row_next;
    logic             step;
    int               w_clamp, h_clamp;

    assign step = (state_reg == ST_RUN) && s_tvalid && !buf_full && !cfg_we;

    // clamp the written size to the supported range
    always_comb begin
        w_clamp = int'(cfg_data);
        h_clamp = int'(cfg_data);
        if (w_clamp < DIM_MIN) begin
            w_clamp = DIM_MIN;
        end else if (w_clamp > MAX_WIDTH) begin
            w_clamp = MAX_WIDTH;
        end
        if (h_clamp < DIM_MIN) begin
            h_clamp = DIM_MIN;
        end else if (h_clamp > H_CAP) begin
            h_clamp = H_CAP;
        end
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_BOARD_WIDTH:  last_col_next = COL_W'(w_clamp - 1);
                CFG_BOARD_HEIGHT: last_row_next = ROW_W'(h_clamp - 1);
                default:          last_col_next = last_col_reg;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        if (cfg_we) begin
            state_next = ST_RUN;
        end else begin
            unique case (state_reg)
                ST_RUN: begin
                    if (step && col_reg == last_col_reg && row_reg != '0) begin
                        state_next = ST_TAIL;
                    end
                end
                ST_TAIL: begin
                    if (!buf_full) begin
                        state_next = (row_reg == last_row_reg) ? ST_FLUSH : ST_RUN;
                    end
                end
                ST_FLUSH: begin
                    if ((col_reg == '0 || !buf_full) && col_reg == last_col_reg) begin
                        state_next = ST_FINAL;
                    end
                end
                ST_FINAL: begin
                    if (!buf_full) begin
                        state_next = ST_RUN;
                    end
                end
                default: state_next = ST_RUN;
            endcase
        end
    end

    // outputs and counters
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        col_next = col_reg;
        row_next = row_reg;
        unique case (state_reg)
            ST_RUN: begin
                s_tready = !buf_full && !cfg_we;
                if (step) begin
                    cmd.push_src  = PUSH_STEP;
                    cmd.mem_we    = 1'b1;
                    cmd.zero_top  = (row_reg == '0);
                    cmd.clear_win = (col_reg == '0);
                    cmd.emit      = (row_reg != '0) && (col_reg != '0);
                    if (col_reg == last_col_reg) begin
                        col_next = '0;
                        // the first row has no tail cell
                        if (row_reg == '0) begin
                            row_next = row_reg + 1'b1;
                        end
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                if (!buf_full) begin
                    cmd.push_src = PUSH_ZERO;
                    cmd.emit     = 1'b1;
                    if (row_reg != last_row_reg) begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (col_reg == '0 || !buf_full) begin
                    cmd.push_src  = PUSH_FLUSH;
                    cmd.clear_win = (col_reg == '0);
                    cmd.emit      = (col_reg != '0);
                    col_next      = (col_reg == last_col_reg) ? '0 : col_reg + 1'b1;
                end
            end
            ST_FINAL: begin
                if (!buf_full) begin
                    cmd.push_src    = PUSH_ZERO;
                    cmd.emit        = 1'b1;
                    cmd.last        = 1'b1;
                    cmd.clear_tally = 1'b1;
                    row_next        = '0;
                end
            end
            default: cmd = '0;
        endcase
        if (cfg_we) begin
            cmd             = '0;
            cmd.clear_tally = 1'b1;
            col_next        = '0;
            row_next        = '0;
        end
    end

    assign wr_addr = col_reg;
    // line store is addressed with the next column so its registered read data matches the current column
    assign rd_addr = col_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            col_reg      <= '0;
            row_reg      <= '0;
            last_col_reg <= COL_W'(RST_W - 1);
            last_row_reg <= ROW_W'(RST_H - 1);
        end else begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
        end
    end

endmodule

// ===== rtl/tclg_datapath.sv =====
// datapath: two-row line store, 3x3 window, next-cell rule and live tallies
`timescale 1ns / 1ps

module tclg_datapath import tclg_pkg::*; #(
    parameter int MAX_WIDTH = 32,
    localparam int COL_W    = $clog2(MAX_WIDTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    input  logic [COL_W-1:0]  wr_addr,
    input  logic [COL_W-1:0]  rd_addr,
    input  logic [CODE_W-1:0] cell_code,
    output result_t           result
);

    // word per column: [1:0] older row, [3:2] newer row
    logic [2*CODE_W-1:0] mem [MAX_WIDTH];
    logic [2*CODE_W-1:0] rd_data_reg;

    // window columns, oldest first; inside a column [1:0] top .. [5:4] bottom
    logic [3*CODE_W-1:0] win_reg  [3];
    logic [3*CODE_W-1:0] win_next [3];
    logic [3*CODE_W-1:0] new_col;
    logic [CODE_W-1:0]   cell_v;
    logic [CODE_W-1:0]   center;
    logic [CODE_W-1:0]   next_code;
    logic [3:0]          n0, n1, total;
    logic [TALLY_W-1:0]  tally0_reg, tally1_reg;
    logic [TALLY_W-1:0]  tally0_new, tally1_new;

    assign cell_v = (cell_code == CODE_BAD) ? CODE_DEAD : cell_code;

    always_comb begin
        unique case (cmd.push_src)
            PUSH_STEP:  new_col = {cell_v, rd_data_reg};
            PUSH_FLUSH: new_col = {CODE_DEAD, rd_data_reg};
            PUSH_ZERO:  new_col = '0;
            PUSH_NONE:  new_col = '0;
            default:    new_col = '0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k] = cmd.clear_win ? '0 : win_reg[k];
        end
        if (cmd.push_src != PUSH_NONE) begin
            win_next[0] = win_next[1];
            win_next[1] = win_next[2];
            win_next[2] = new_col;
        end
    end

    // neighbour counts per colour
    always_comb begin
        n0 = '0;
        n1 = '0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                if (!(k == 1 && j == 1)) begin
                    if (win_next[k][2*j +: 2] == CODE_P0) begin
                        n0 = n0 + 4'd1;
                    end else if (win_next[k][2*j +: 2] == CODE_P1) begin
                        n1 = n1 + 4'd1;
                    end
                end
            end
        end
    end

    assign center = win_next[1][3:2];
    assign total  = n0 + n1;

    always_comb begin
        next_code = CODE_DEAD;
        if (center == CODE_DEAD) begin
            // birth takes the majority colour, ties go to player one
            if (total == 4'd3) begin
                next_code = (n0 > n1) ? CODE_P0 : CODE_P1;
            end
        end else if (total == 4'd2 || total == 4'd3) begin
            next_code = center;
        end
    end

    always_comb begin
        tally0_new = tally0_reg;
        tally1_new = tally1_reg;
        if (next_code == CODE_P0 && tally0_reg != TALLY_MAX) begin
            tally0_new = tally0_reg + 1'b1;
        end
        if (next_code == CODE_P1 && tally1_reg != TALLY_MAX) begin
            tally1_new = tally1_reg + 1'b1;
        end
    end

    always_comb begin
        result.next_code     = next_code;
        result.frame_last    = cmd.last;
        result.count_player0 = cmd.last ? tally0_new : '0;
        result.count_player1 = cmd.last ? tally1_new : '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[wr_addr] <= {cell_v, cmd.zero_top ? CODE_DEAD : rd_data_reg[3:2]};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            win_reg[k] <= win_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tally0_reg <= '0;
            tally1_reg <= '0;
        end else if (cmd.clear_tally) begin
            tally0_reg <= '0;
            tally1_reg <= '0;
        end else if (cmd.emit) begin
            tally0_reg <= tally0_new;
            tally1_reg <= tally1_new;
        end
    end

endmodule

// ===== rtl/tclg_out_buf.sv =====
// two-entry result queue between the window evaluator and the output channel
`timescale 1ns / 1ps

module tclg_out_buf import tclg_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    enq,
    input  result_t enq_data,
    output logic    full,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_data
);

    result_t    slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       deq;

    assign m_tvalid = (count_reg != 2'd0);
    assign full     = (count_reg == 2'd2);
    assign deq      = m_tvalid && m_tready;
    assign m_data   = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (enq && !deq) begin
            count_next = count_reg + 2'd1;
        end else if (deq && !enq) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (enq) begin
            slot_reg[wr_ptr_reg] <= enq_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (enq) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (deq) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/two_color_life_generation_core.sv =====
// top level of the two-colour life generation core
//
//  channel | direction | tdata (lowest bit first)                       | tlast
//  s_      | in        | [1:0] cell_code, [7:2] zero                    | -
//  m_      | out       | [1:0] next_code, [12:2] count_player0,
//          |           | [23:13] count_player1                          | frame_last
//  cfg_    | in        | cfg_index 0 board_width, 1 board_height        | -
//
// one cell is taken per cycle while the result buffer has room and cfg_we is low; the last cell of every row
// after the first is followed by a step that emits the right-edge cell, and the last cell of a frame is followed by
// a flush pass over the final row and a closing step that marks frame_last. the single window evaluator
// issues at most one result per cycle.
// results queue in a two-entry buffer; a full buffer stalls s_tready and the flush.
// reset is synchronous and takes effect at once: the line store needs no clearing pass.
`timescale 1ns / 1ps

module two_color_life_generation_core import tclg_pkg::*; #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [1:0] cell_code
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // [1:0] next_code, [12:2] count_player0, [23:13] count_player1
    output logic             m_tlast
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    dp_cmd_t          cmd;
    logic [COL_W-1:0] wr_addr, rd_addr;
    logic             buf_full;
    result_t          result, m_res;

    tclg_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .buf_full (buf_full),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr)
    );

    tclg_datapath #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .cell_code(s_tdata[1:0]),
        .result   (result)
    );

    tclg_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enq     (cmd.emit),
        .enq_data(result),
        .full    (buf_full),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_data  (m_res)
    );

    assign m_tdata = {m_res.count_player1, m_res.count_player0, m_res.next_code};
    assign m_tlast = m_res.frame_last;

endmodule

// ===== rtl/tclg_checker.sv =====
// port-level checks on the two-colour life generation core
`timescale 1ns / 1ps

module tclg_checker import tclg_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // nothing left over from before reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled transaction is not withdrawn
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // player counts appear on the final cell only
    a_counts_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[23:2] == 22'd0)
        else $error("counts set outside the final cell");

    // the rule never yields the unused code
    a_code_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != CODE_BAD)
        else $error("illegal next cell code");

endmodule

bind two_color_life_generation_core tclg_checker u_tclg_checker (.*);
